// ----- rtl/tkbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tkbp_pkg
// shared types and codes for the top-k beam pruning store
// ----------------------------------------------------------------------------
package tkbp_pkg;

   localparam int unsigned STATUS_W = 3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SKIPPED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PRUNED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ    = 3'd5;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // memory read address select
   localparam logic [1:0] RSEL_I    = 2'd0;
   localparam logic [1:0] RSEL_PREV = 2'd1;
   localparam logic [1:0] RSEL_IDX  = 2'd2;
   localparam logic [1:0] RSEL_KTH  = 2'd3;

   localparam logic [31:0] SCORE_INF = 32'h7FFF_FFFF;

   typedef struct packed {
      logic                load_item;
      logic                load_sum;
      logic                store_add;
      logic                sort_init;
      logic                mem_rd_en;
      logic [1:0]          rd_sel;
      logic                cap_key;
      logic                shift_write;
      logic                place_write;
      logic                prune_commit;
      logic                idx_clr;
      logic                out_load_add;
      logic                out_load_read;
      logic [STATUS_W-1:0] out_code;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_empty;
      logic reject;
      logic full;
      logic prune_needed;
      logic count_zero;
      logic sort_done;
      logic j_zero;
      logic prev_less;
      logic rd_last;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/tkbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tkbp_ctrl
// sequencer for add, prune (insertion sort) and read-out
// ----------------------------------------------------------------------------
module tkbp_ctrl
   import tkbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SUM      = 4'd1;
   localparam logic [3:0] S_DECIDE   = 4'd2;
   localparam logic [3:0] S_EMIT     = 4'd3;
   localparam logic [3:0] S_SORT_I   = 4'd4;
   localparam logic [3:0] S_SORT_CAP = 4'd5;
   localparam logic [3:0] S_SORT_PRV = 4'd6;
   localparam logic [3:0] S_SORT_CMP = 4'd7;
   localparam logic [3:0] S_THR_RD   = 4'd8;
   localparam logic [3:0] S_THR_LD   = 4'd9;
   localparam logic [3:0] S_RD_ADDR  = 4'd10;
   localparam logic [3:0] S_RD_LOAD  = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd          = '0;
      cmd.out_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load_item = 1'b1;
               state_in      = S_SUM;
            end
         end
         S_SUM: begin
            cmd.load_sum = 1'b1;
            if (sts.is_read) begin
               cmd.idx_clr = 1'b1;
               state_in    = sts.count_zero ? S_IDLE : S_RD_ADDR;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (sts.is_empty) begin
               code_in  = ST_SKIPPED;
               state_in = S_EMIT;
            end else if (sts.reject) begin
               code_in  = ST_REJECT;
               state_in = S_EMIT;
            end else if (sts.full) begin
               code_in  = ST_DROPPED;
               state_in = S_EMIT;
            end else begin
               cmd.store_add = 1'b1;
               code_in       = ST_STORED;
               state_in      = sts.prune_needed ? S_SORT_I : S_EMIT;
               cmd.sort_init = sts.prune_needed;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load_add = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_SORT_I: begin
            if (sts.sort_done) begin
               state_in = S_THR_RD;
            end else begin
               cmd.mem_rd_en = 1'b1;
               cmd.rd_sel    = RSEL_I;
               state_in      = S_SORT_CAP;
            end
         end
         S_SORT_CAP: begin
            cmd.cap_key = 1'b1;
            state_in    = S_SORT_PRV;
         end
         S_SORT_PRV: begin
            if (sts.j_zero) begin
               cmd.place_write = 1'b1;
               state_in        = S_SORT_I;
            end else begin
               cmd.mem_rd_en = 1'b1;
               cmd.rd_sel    = RSEL_PREV;
               state_in      = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            if (sts.prev_less) begin
               cmd.shift_write = 1'b1;
               state_in        = S_SORT_PRV;
            end else begin
               cmd.place_write = 1'b1;
               state_in        = S_SORT_I;
            end
         end
         S_THR_RD: begin
            cmd.mem_rd_en = 1'b1;
            cmd.rd_sel    = RSEL_KTH;
            state_in      = S_THR_LD;
         end
         S_THR_LD: begin
            cmd.prune_commit = 1'b1;
            code_in          = ST_PRUNED;
            state_in         = S_EMIT;
         end
         S_RD_ADDR: begin
            cmd.mem_rd_en = 1'b1;
            cmd.rd_sel    = RSEL_IDX;
            state_in      = S_RD_LOAD;
         end
         S_RD_LOAD: begin
            if (sts.out_free) begin
               cmd.out_load_read = 1'b1;
               state_in          = sts.rd_last ? S_IDLE : S_RD_ADDR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_STORED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ----- rtl/tkbp_datapath.sv -----
// ----------------------------------------------------------------------------
// tkbp_datapath
// score/handle store, totals, threshold, sort registers and result register
// ----------------------------------------------------------------------------
module tkbp_datapath
   import tkbp_pkg::*;
#(
   parameter int unsigned MAX_LIMIT    = 32,
   parameter int unsigned MAX_CHILDREN = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [5:0]          limit,
   input  logic                in_op,
   input  logic [15:0]         in_handle,
   input  logic                in_empty,
   input  logic [31:0]         in_base,
   input  logic [2:0]          in_nch,
   input  logic [4*32-1:0]     in_child,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [STATUS_W-1:0] out_status,
   output logic [15:0]         out_handle,
   output logic [31:0]         out_score,
   output logic [6:0]          out_count,
   output logic                out_last
);

   localparam int unsigned DEPTH = 2 * MAX_LIMIT;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;
   localparam int unsigned CH_LIM = (MAX_CHILDREN < 4) ? MAX_CHILDREN : 4;

   // item registers
   logic              op_ff, empty_ff;
   logic [15:0]       handle_ff;
   logic [31:0]       base_ff, total_ff, thr_ff;
   logic [2:0]        nch_ff;
   logic [4*32-1:0]   child_ff;
   logic [CNT_W-1:0]  cnt_ff, i_ff, j_ff, idx_ff;
   logic [31:0]       key_score_ff;
   logic [15:0]       key_handle_ff;

   // store
   logic [31:0]       score_mem [DEPTH];
   logic [15:0]       handle_mem [DEPTH];
   logic [31:0]       rd_score_ff;
   logic [15:0]       rd_handle_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_en;
   logic [31:0]       wr_score;
   logic [15:0]       wr_handle;

   logic [CMP_W-1:0]  k_ext, lim_ext, cnt_ext;
   logic [CNT_W-1:0]  k_cnt;
   logic              k_nz;
   logic [2:0]        nch_eff;
   logic signed [34:0] sum;
   logic [31:0]       total_sat;

   logic              valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [15:0]       ohandle_ff;
   logic [31:0]       oscore_ff;
   logic [6:0]        ocount_ff;
   logic              olast_ff;

   assign lim_ext = CMP_W'(limit);
   assign k_ext   = (lim_ext > CMP_W'(MAX_LIMIT)) ? CMP_W'(MAX_LIMIT) : lim_ext;
   assign k_cnt   = CNT_W'(k_ext);
   assign k_nz    = (k_ext != '0);
   assign cnt_ext = CMP_W'(cnt_ff);

   // child count clamp and saturating total
   assign nch_eff = (nch_ff > 3'(CH_LIM)) ? 3'(CH_LIM) : nch_ff;
   always_comb begin
      sum = 35'(signed'(base_ff));
      for (int c = 0; c < 4; c++) begin
         if (3'(c) < nch_eff) sum = sum + 35'(signed'(child_ff[c*32 +: 32]));
      end
      if (sum > 35'sh0_7FFF_FFFF)       total_sat = 32'h7FFF_FFFF;
      else if (sum < -35'sh0_8000_0000) total_sat = 32'h8000_0000;
      else                              total_sat = sum[31:0];
   end

   assign sts.is_read      = (op_ff == OP_READ);
   assign sts.is_empty     = empty_ff;
   assign sts.reject       = k_nz && (cnt_ext > k_ext) &&
                             ($signed(total_ff) < $signed(thr_ff));
   assign sts.full         = (cnt_ext >= CMP_W'(DEPTH));
   assign sts.prune_needed = k_nz && ((cnt_ext + 1'b1) >= (k_ext << 1));
   assign sts.count_zero   = (cnt_ff == '0);
   assign sts.sort_done    = (i_ff >= cnt_ff);
   assign sts.j_zero       = (j_ff == '0);
   assign sts.prev_less    = ($signed(rd_score_ff) < $signed(key_score_ff));
   assign sts.rd_last      = ((idx_ff + 1'b1) == cnt_ff);
   assign sts.out_free     = !valid_ff || out_ready;

   always_comb begin
      unique case (cmd.rd_sel)
         RSEL_I:    rd_addr = i_ff[AW-1:0];
         RSEL_PREV: rd_addr = AW'(j_ff - 1'b1);
         RSEL_IDX:  rd_addr = idx_ff[AW-1:0];
         RSEL_KTH:  rd_addr = AW'(k_cnt - 1'b1);
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en     = cmd.store_add || cmd.shift_write || cmd.place_write;
      wr_addr   = j_ff[AW-1:0];
      wr_score  = key_score_ff;
      wr_handle = key_handle_ff;
      priority if (cmd.store_add) begin
         wr_addr   = cnt_ff[AW-1:0];
         wr_score  = total_ff;
         wr_handle = handle_ff;
      end else if (cmd.shift_write) begin
         wr_score  = rd_score_ff;
         wr_handle = rd_handle_ff;
      end else begin
         wr_score  = key_score_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_addr]  <= wr_score;
         handle_mem[wr_addr] <= wr_handle;
      end
      if (cmd.mem_rd_en) begin
         rd_score_ff  <= score_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= in_op;
         empty_ff  <= in_empty;
         handle_ff <= in_handle;
         base_ff   <= in_base;
         nch_ff    <= in_nch;
         child_ff  <= in_child;
      end
      if (cmd.load_sum) total_ff <= total_sat;
      if (cmd.sort_init) i_ff <= CNT_W'(1);
      else if (cmd.place_write) i_ff <= i_ff + 1'b1;
      if (cmd.cap_key) begin
         key_score_ff  <= rd_score_ff;
         key_handle_ff <= rd_handle_ff;
         j_ff          <= i_ff;
      end else if (cmd.shift_write) begin
         j_ff <= j_ff - 1'b1;
      end
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.out_load_read) idx_ff <= idx_ff + 1'b1;
      if (cmd.out_load_add) begin
         status_ff  <= cmd.out_code;
         ohandle_ff <= handle_ff;
         oscore_ff  <= (cmd.out_code == ST_SKIPPED) ? 32'd0 : total_ff;
         ocount_ff  <= 7'(cnt_ff);
         olast_ff   <= 1'b1;
      end else if (cmd.out_load_read) begin
         status_ff  <= ST_READ;
         ohandle_ff <= rd_handle_ff;
         oscore_ff  <= rd_score_ff;
         ocount_ff  <= 7'(cnt_ff);
         olast_ff   <= sts.rd_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         thr_ff   <= SCORE_INF;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.store_add) begin
            cnt_ff <= cnt_ff + 1'b1;
            if ((!k_nz || (cnt_ext < k_ext)) && ($signed(total_ff) < $signed(thr_ff)))
               thr_ff <= total_ff;
         end else if (cmd.prune_commit) begin
            cnt_ff <= k_cnt;
            thr_ff <= rd_score_ff;
         end
         if (cmd.out_load_add || cmd.out_load_read) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   assign out_valid  = valid_ff;
   assign out_status = status_ff;
   assign out_handle = ohandle_ff;
   assign out_score  = oscore_ff;
   assign out_count  = ocount_ff;
   assign out_last   = olast_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ext <= CMP_W'(DEPTH)) else $error("entry count above store depth");
   a_shift_j: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_write |-> (j_ff != '0)) else $error("shift past store head");
   a_out_one: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load_add && cmd.out_load_read)) else $error("two result loads");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_add || cmd.out_load_read) |-> (!valid_ff || out_ready))
      else $error("result overwritten before taken");

endmodule

// ----- rtl/top_k_beam_pruning_store_unit.sv -----
// ----------------------------------------------------------------------------
// top_k_beam_pruning_store_unit
// bounded store of scored candidates with top-k pruning and read-out
// ----------------------------------------------------------------------------
// add: the request is latched, summed and decided, then the result is loaded
//   when the result register is free; the next request waits until then
// prune: insertion sort in the single-port store, then the k-th score is read
//   back as the new threshold; stalls requests
// read-out: entries go one at a time through the registered store read port
// reset clears entry count, threshold (to +inf), limit (to 32); store contents
//   stay undefined and are only read below the entry count
// ----------------------------------------------------------------------------
module top_k_beam_pruning_store_unit
   import tkbp_pkg::*;
#(
   parameter int unsigned MAX_LIMIT    = 32,
   parameter int unsigned MAX_CHILDREN = 4
) (
   input  logic         clock,
   input  logic         reset,
   // configuration: rule_limit
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_data,
   // requests
   input  logic         req_tvalid,
   output logic         req_tready,
   // rule_handle[15:0], rule_empty[16], base_score[48:17], child_count[51:49],
   // child_score_0[83:52], child_score_1[115:84], child_score_2[147:116],
   // child_score_3[179:148], zero fill
   input  logic [183:0] req_tdata,
   input  logic [0:0]   req_tuser,   // operation[0]
   // results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_handle[15:0], entry_score[47:16], stored_count[54:48], zero fill
   output logic [55:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser,   // status[2:0]
   output logic         rsp_tlast    // last
);

   cmd_type             cmd;
   sts_type             sts;
   logic [5:0]          limit_ff;
   logic [STATUS_W-1:0] out_status;
   logic [15:0]         out_handle;
   logic [31:0]         out_score;
   logic [6:0]          out_count;

   // limit register, written only while idle
   assign csr_ready = req_tready;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 6'd32;
      else if (csr_valid && csr_ready) limit_ff <= csr_data;
   end

   tkbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && req_tready),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tkbp_datapath #(
      .MAX_LIMIT    (MAX_LIMIT),
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .limit      (limit_ff),
      .in_op      (req_tuser[0]),
      .in_handle  (req_tdata[15:0]),
      .in_empty   (req_tdata[16]),
      .in_base    (req_tdata[48:17]),
      .in_nch     (req_tdata[51:49]),
      .in_child   (req_tdata[179:52]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (out_status),
      .out_handle (out_handle),
      .out_score  (out_score),
      .out_count  (out_count),
      .out_last   (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {1'b0, out_count, out_score, out_handle};
   assign rsp_tuser = out_status;

endmodule

// ----- sim/top_k_beam_pruning_store_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_beam_pruning_store_unit_tb
// streams add and read-out requests into the pruning store, predicts every
// result with a behavioral copy of the store and checks them field by field
// ----------------------------------------------------------------------------
module top_k_beam_pruning_store_unit_tb
   import tkbp_pkg::*;
;

   localparam int unsigned MAX_LIMIT    = 32;
   localparam int unsigned MAX_CHILDREN = 4;
   localparam int unsigned DEPTH        = 2 * MAX_LIMIT;
   localparam int unsigned WATCHDOG     = 200000;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef struct packed {
      logic        op;
      logic [15:0] handle;
      logic        empty;
      logic [31:0] base;
      logic [2:0]  nchild;
      logic [31:0] c0;
      logic [31:0] c1;
      logic [31:0] c2;
      logic [31:0] c3;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] handle;
      logic [31:0] score;
      logic [6:0]  count;
      logic        last;
   } result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [5:0]   csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   top_k_beam_pruning_store_unit #(
      .MAX_LIMIT    (MAX_LIMIT),
      .MAX_CHILDREN (MAX_CHILDREN)
   ) i_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predicted store: own copy of scores, handles, count, threshold, limit
   // ------------------------------------------------------------------------
   logic signed [31:0] pred_score [DEPTH];
   logic [15:0]        pred_handle [DEPTH];
   int unsigned        pred_count = 0;
   logic signed [31:0] pred_thresh = SCORE_INF;
   int unsigned        pred_limit = 32;

   request_type pending_reqs [$];
   result_type  expected_results [$];
   int unsigned fail_count = 0;
   int unsigned idle_pct = 0;     // sender idle chance in percent
   int unsigned stall_pct = 0;    // receiver stall chance in percent
   logic        hold_req = 1'b0;  // asks the receiver for one long hold-off
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;    // hold-off cycles still to go
   int unsigned quiet_cycles = 0;
   logic        req_accepted = 1'b0;

   function automatic void queue_request(request_type q);
      pending_reqs.insert(pending_reqs.size(), q);
   endfunction

   function automatic void expect_result(result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic result_type make_result(logic [2:0] st, logic [15:0] h,
                                              logic [31:0] sc, int unsigned cnt,
                                              logic lst);
      result_type r;
      r.status = st;
      r.handle = h;
      r.score  = sc;
      r.count  = cnt[6:0];
      r.last   = lst;
      return r;
   endfunction

   // stable best-first order, then cut to k
   task automatic prune_to_best(int unsigned k);
      logic signed [31:0] s;
      logic [15:0]        h;
      int                 j;
      for (int i = 1; i < pred_count; i++) begin
         s = pred_score[i];
         h = pred_handle[i];
         j = i;
         while (j > 0 && pred_score[j-1] < s) begin
            pred_score[j]  = pred_score[j-1];
            pred_handle[j] = pred_handle[j-1];
            j--;
         end
         pred_score[j]  = s;
         pred_handle[j] = h;
      end
      pred_thresh = pred_score[k-1];
      pred_count  = k;
   endtask

   task automatic predict_request(request_type q);
      int unsigned        k;
      int unsigned        nch;
      longint             sum;
      logic signed [31:0] total;
      logic signed [31:0] kids [4];
      k = (pred_limit > MAX_LIMIT) ? MAX_LIMIT : pred_limit;
      if (q.op == OP_READ) begin
         for (int i = 0; i < pred_count; i++)
            expect_result(make_result(ST_READ, pred_handle[i],
               pred_score[i], pred_count, i + 1 == pred_count));
         return;
      end
      if (q.empty) begin
         expect_result(make_result(ST_SKIPPED, q.handle, '0, pred_count, 1'b1));
         return;
      end
      kids = '{q.c0, q.c1, q.c2, q.c3};
      nch = q.nchild;
      if (nch > MAX_CHILDREN) nch = MAX_CHILDREN;
      if (nch > 4) nch = 4;
      sum = longint'(signed'(q.base));
      for (int i = 0; i < nch; i++) sum += longint'(kids[i]);
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      total = sum[31:0];
      // over the limit and below threshold: rejected
      if (k != 0 && pred_count > k && total < pred_thresh) begin
         expect_result(make_result(ST_REJECT, q.handle, total, pred_count, 1'b1));
         return;
      end
      if (pred_count >= DEPTH) begin
         expect_result(make_result(ST_DROPPED, q.handle, total, pred_count, 1'b1));
         return;
      end
      pred_score[pred_count]  = total;
      pred_handle[pred_count] = q.handle;
      pred_count++;
      if ((k == 0 || pred_count <= k) && total < pred_thresh)
         pred_thresh = total;
      if (k != 0 && pred_count >= 2 * k) begin
         prune_to_best(k);
         expect_result(make_result(ST_PRUNED, q.handle, total, pred_count, 1'b1));
         return;
      end
      expect_result(make_result(ST_STORED, q.handle, total, pred_count, 1'b1));
   endtask

   // ------------------------------------------------------------------------
   // driver: offers queued requests at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, pending_reqs[0].c3, pending_reqs[0].c2,
                           pending_reqs[0].c1, pending_reqs[0].c0,
                           pending_reqs[0].nchild, pending_reqs[0].base,
                           pending_reqs[0].empty, pending_reqs[0].handle};
            req_tuser  <= pending_reqs[0].op;
            void'(pending_reqs.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // the accepted flag is sampled at the rising edge, used at the next fall
   always @(posedge clock) begin
      req_accepted <= req_tvalid && req_tready;
      if (req_tvalid && req_tready)
         predict_request(request_type'({req_tuser[0], req_tdata[15:0],
            req_tdata[16], req_tdata[48:17], req_tdata[51:49],
            req_tdata[83:52], req_tdata[115:84], req_tdata[147:116],
            req_tdata[179:148]}));
   end

   // receiver readiness, with a counted long hold-off when asked
   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES - 1;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compares each accepted result with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_result(rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16],
                           rsp_tdata[54:48], rsp_tlast);
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d handle %h", got.status,
                   got.handle);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, got.status);
               fail_count++;
            end
            if (got.handle !== want.handle) begin
               $error("entry_handle: expected %h actual %h", want.handle,
                      got.handle);
               fail_count++;
            end
            if (got.score !== want.score) begin
               $error("entry_score: expected %h actual %h", want.score, got.score);
               fail_count++;
            end
            if (got.count !== want.count) begin
               $error("stored_count: expected %0d actual %0d", want.count,
                      got.count);
               fail_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, got.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic logic [31:0] rand_score();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(7) << 16;    // small, many ties
         default: return $urandom();
      endcase
   endfunction

   function automatic request_type rand_add();
      request_type q;
      q.op     = OP_ADD;
      q.handle = 16'($urandom());
      q.empty  = ($urandom_range(15) == 0);
      q.base   = rand_score();
      q.nchild = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                                            3'($urandom_range(4));
      q.c0     = rand_score();
      q.c1     = rand_score();
      q.c2     = rand_score();
      q.c3     = rand_score();
      return q;
   endfunction

   function automatic request_type read_req();
      request_type q;
      q = $urandom_range(1) ? rand_add() : '0;  // add fields are ignored
      q.op = OP_READ;
      return q;
   endfunction

   // waits until everything sent has been answered, then lets the block settle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [5:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      pred_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      request_type q;
      logic [5:0]  limits [6] = '{6'd32, 6'd0, 6'd1, 6'd5, 6'd63, 6'd3};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty read-out, extremes, saturation, skip, tie order
      queue_request(read_req());
      q = '0;
      q.handle = 16'hFFFF; q.base = 32'h7FFF_FFFF; q.nchild = 3'd4;
      q.c0 = 32'h7FFF_FFFF; q.c1 = 32'h7FFF_FFFF;
      q.c2 = 32'h7FFF_FFFF; q.c3 = 32'h7FFF_FFFF;
      queue_request(q);
      q.handle = 16'h0000; q.base = 32'h8000_0000; q.c0 = 32'h8000_0000;
      q.c1 = 32'h8000_0000; q.c2 = 32'h8000_0000; q.c3 = 32'h8000_0000;
      queue_request(q);
      q.nchild = 3'd7; q.base = 32'h0001_0000; q.c0 = 32'h1;
      queue_request(q);
      q.empty = 1'b1; q.handle = 16'h5A5A;
      queue_request(q);
      q = '0; q.base = 32'h0002_0000;
      for (int i = 0; i < 3; i++) begin
         q.handle = 16'h100 + 16'(i);
         queue_request(q);
      end
      queue_request(read_req());
      drain();

      // limit 0 fills the whole store and then drops
      write_limit(6'd0);
      for (int i = 0; i < 70; i++) queue_request(rand_add());
      queue_request(read_req());
      // long hold-off while requests keep coming
      hold_req = 1'b1;
      drain();

      // random phases over several limits and idling patterns
      for (int p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int i = 0; i < 40; i++)
            queue_request(($urandom_range(11) == 0) ? read_req() : rand_add());
         queue_request(read_req());
         drain();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
